/* src/dnsrp_pkg.sv */
// Shared types and constants for the DNS response parser.
`default_nettype none

package dnsrp_pkg;

  // Largest rdata capture supported by the record fields (two 64-bit words)
  localparam int unsigned RDATA_MAX         = 16;
  localparam int unsigned DNSRP_RDATA_BYTES = 16;

  // Result queue sizing
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PW    = $clog2(QUEUE_DEPTH);

  // Result kinds
  localparam logic KIND_RECORD  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Address kinds
  localparam logic [1:0] ADDR_OTHER = 2'd0;
  localparam logic [1:0] ADDR_IPV4  = 2'd1;
  localparam logic [1:0] ADDR_IPV6  = 2'd2;

  // Status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_CLIPPED = 2'd1;
  localparam logic [1:0] STATUS_EARLY   = 2'd2;

  // Protocol constants
  localparam logic [7:0]  NAME_END     = 8'h00;
  localparam logic [7:0]  PTR_MASK     = 8'hC0;
  localparam logic [15:0] TYPE_A       = 16'd1;
  localparam logic [15:0] TYPE_AAAA    = 16'd28;
  localparam logic [15:0] LEN_IPV4     = 16'd4;
  localparam logic [15:0] LEN_IPV6     = 16'd16;
  localparam logic [3:0]  HEADER_LAST  = 4'd11;
  localparam logic [3:0]  COUNT_HI_POS = 4'd6;
  localparam logic [3:0]  COUNT_LO_POS = 4'd7;
  localparam logic [3:0]  QTAIL_BYTES  = 4'd4;
  localparam logic [3:0]  FIXED_BYTES  = 4'd10;

  // One result item
  typedef struct packed {
    logic        result_kind;
    logic [15:0] name_word;
    logic [15:0] record_type;
    logic [15:0] record_class;
    logic [31:0] time_to_live;
    logic [15:0] rdata_length;
    logic [63:0] rdata_front;
    logic [63:0] rdata_back;
    logic [1:0]  address_kind;
    logic [15:0] answer_total;
    logic [1:0]  status;
    logic        last_of_run;
  } result_t;

  // Pushes from the parser into the result queue for one byte
  typedef struct packed {
    logic first;
    logic second;
  } push_t;

endpackage

`default_nettype wire

/* src/dns_response_parser_unit.sv */
// Top level of the streaming DNS response parser.
//
//  channel | dir | ports                                  | transfer when
//  --------+-----+----------------------------------------+--------------------------
//  in      | in  | in_data_byte, in_last_byte             | in_valid  & !in_stall
//  out     | out | out_result_kind .. out_last_of_run     | out_valid & !out_stall
//
// One byte is taken per clock while in_stall is low; its results enter the queue.
// Results go into a four-entry queue; a last byte that also ends an answer pushes
// two results (record, summary), every other byte at most one.
// in_stall rises when fewer than two queue entries are free, so only a stalled
// output side slows the input. Reset (rst_n low, synchronous) empties the queue
// and returns the parser to the header phase.
`default_nettype none

module dns_response_parser_unit #(
  parameter int unsigned RDATA_BYTES = dnsrp_pkg::DNSRP_RDATA_BYTES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_result_kind,
  output logic [15:0]      out_name_word,
  output logic [15:0]      out_record_type,
  output logic [15:0]      out_record_class,
  output logic [31:0]      out_time_to_live,
  output logic [15:0]      out_rdata_length,
  output logic [63:0]      out_rdata_front,
  output logic [63:0]      out_rdata_back,
  output logic [1:0]       out_address_kind,
  output logic [15:0]      out_answer_total,
  output logic [1:0]       out_status,
  output logic             out_last_of_run
);

  logic               take;
  dnsrp_pkg::push_t   push;
  dnsrp_pkg::result_t res0, res1, head;

  assign take = in_valid & ~in_stall;

  dnsrp_parser #(.RDATA_BYTES(RDATA_BYTES)) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .push      (push),
    .res0      (res0),
    .res1      (res1)
  );

  dnsrp_result_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .res0      (res0),
    .res1      (res1),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  // Output field breakout
  assign out_result_kind  = head.result_kind;
  assign out_name_word    = head.name_word;
  assign out_record_type  = head.record_type;
  assign out_record_class = head.record_class;
  assign out_time_to_live = head.time_to_live;
  assign out_rdata_length = head.rdata_length;
  assign out_rdata_front  = head.rdata_front;
  assign out_rdata_back   = head.rdata_back;
  assign out_address_kind = head.address_kind;
  assign out_answer_total = head.answer_total;
  assign out_status       = head.status;
  assign out_last_of_run  = head.last_of_run;

  // Checks
  a_two_needs_one: assert property (@(posedge clk) disable iff (!rst_n)
    push.second |-> push.first)
    else $error("second result pushed without a first");

  a_no_push_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> !push.first)
    else $error("result pushed while input stalled");

  a_summary_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind == dnsrp_pkg::KIND_SUMMARY) |-> out_last_of_run)
    else $error("summary transfer without last_of_run");

  a_record_no_total: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind == dnsrp_pkg::KIND_RECORD) |-> out_answer_total == 16'd0)
    else $error("record transfer carries an answer total");

endmodule

`default_nettype wire

/* src/dnsrp_parser.sv */
// Byte-wise parse state and result formation for the DNS response parser.
`default_nettype none

module dnsrp_parser #(
  parameter int unsigned RDATA_BYTES = dnsrp_pkg::DNSRP_RDATA_BYTES
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              take,
  input  wire logic [7:0]        data_byte,
  input  wire logic              last_byte,
  output dnsrp_pkg::push_t       push,
  output dnsrp_pkg::result_t     res0,
  output dnsrp_pkg::result_t     res1
);

  localparam int unsigned CW = $clog2(RDATA_BYTES + 1);

  typedef enum logic [3:0] {
    PH_HEADER, PH_QNAME, PH_QLABEL, PH_QPTR, PH_QTAIL,
    PH_ANAME, PH_ALABEL, PH_APTR, PH_FIXED, PH_RDATA, PH_DONE
  } phase_t;

  phase_t      phase_r, phase_nxt, cap_phase;
  logic [3:0]  hpos_r, hpos_nxt, cap_hpos, hpos_inc;
  logic [15:0] left_r, left_nxt, cap_left, left_dec;
  logic [15:0] ans_left_r, ans_left_nxt, cap_ans_left;
  logic [15:0] decl_r, decl_nxt, cap_decl;
  logic [15:0] name_r, name_nxt, cap_name;
  logic [1:0]  seen_r, seen_nxt, cap_seen;
  logic [15:0] type_r, type_nxt, cap_type;
  logic [15:0] class_r, class_nxt, cap_class;
  logic [31:0] ttl_r, ttl_nxt, cap_ttl;
  logic [15:0] len_r, len_nxt, cap_len;
  logic [7:0]  store_r   [RDATA_BYTES];
  logic [7:0]  store_nxt [RDATA_BYTES];
  logic [7:0]  cap_store [RDATA_BYTES];
  logic [CW-1:0] ridx_r, ridx_nxt, cap_ridx;
  logic        emit, start_rec;
  logic [8*dnsrp_pkg::RDATA_MAX-1:0] flat;
  logic [1:0]  addr_kind;
  dnsrp_pkg::result_t record, summary;

  assign hpos_inc = hpos_r + 4'd1;
  assign left_dec = left_r - 16'd1;

  // Apply the byte to the parse state
  always_comb begin
    cap_phase    = phase_r;
    cap_hpos     = hpos_r;
    cap_left     = left_r;
    cap_ans_left = ans_left_r;
    cap_decl     = decl_r;
    cap_name     = name_r;
    cap_seen     = seen_r;
    cap_type     = type_r;
    cap_class    = class_r;
    cap_ttl      = ttl_r;
    cap_len      = len_r;
    cap_store    = store_r;
    cap_ridx     = ridx_r;
    emit         = 1'b0;
    start_rec    = 1'b0;
    if (take) begin
      // first two bytes of each answer
      if (phase_r >= PH_ANAME && phase_r <= PH_RDATA && seen_r < 2'd2) begin
        cap_name = {name_r[7:0], data_byte};
        cap_seen = seen_r + 2'd1;
      end
      unique case (phase_r)
        PH_HEADER: begin
          if (hpos_r == dnsrp_pkg::COUNT_HI_POS) begin
            cap_decl = {data_byte, 8'h00};
          end else if (hpos_r == dnsrp_pkg::COUNT_LO_POS) begin
            cap_decl = decl_r | {8'h00, data_byte};
          end
          if (hpos_r >= dnsrp_pkg::HEADER_LAST) begin
            cap_ans_left = cap_decl;
            cap_phase    = PH_QNAME;
            cap_hpos     = 4'd0;
          end else begin
            cap_hpos = hpos_inc;
          end
        end
        PH_QNAME, PH_ANAME: begin
          if (data_byte == dnsrp_pkg::NAME_END) begin
            cap_phase = (phase_r == PH_ANAME) ? PH_FIXED : PH_QTAIL;
            cap_hpos  = 4'd0;
          end else if ((data_byte & dnsrp_pkg::PTR_MASK) == dnsrp_pkg::PTR_MASK) begin
            cap_phase = (phase_r == PH_ANAME) ? PH_APTR : PH_QPTR;
          end else begin
            cap_left  = {8'h00, data_byte};
            cap_phase = (phase_r == PH_ANAME) ? PH_ALABEL : PH_QLABEL;
          end
        end
        PH_QLABEL, PH_ALABEL: begin
          cap_left = left_dec;
          if (left_dec == 16'd0) begin
            cap_phase = (phase_r == PH_QLABEL) ? PH_QNAME : PH_ANAME;
          end
        end
        PH_QPTR, PH_APTR: begin
          cap_phase = (phase_r == PH_APTR) ? PH_FIXED : PH_QTAIL;
          cap_hpos  = 4'd0;
        end
        PH_QTAIL: begin
          cap_hpos = hpos_inc;
          if (hpos_inc >= dnsrp_pkg::QTAIL_BYTES) begin
            cap_hpos = 4'd0;
            if (ans_left_r == 16'd0) begin
              cap_phase = PH_DONE;
            end else begin
              start_rec = 1'b1;
              cap_phase = PH_ANAME;
            end
          end
        end
        PH_FIXED: begin
          if (hpos_r < 4'd2) begin
            cap_type = {type_r[7:0], data_byte};
          end else if (hpos_r < 4'd4) begin
            cap_class = {class_r[7:0], data_byte};
          end else if (hpos_r < 4'd8) begin
            cap_ttl = {ttl_r[23:0], data_byte};
          end else begin
            cap_len = {len_r[7:0], data_byte};
          end
          cap_hpos = hpos_inc;
          if (hpos_inc >= dnsrp_pkg::FIXED_BYTES) begin
            cap_hpos = 4'd0;
            if (cap_len == 16'd0) begin
              emit = 1'b1;
            end else begin
              cap_left  = cap_len;
              cap_ridx  = '0;
              cap_phase = PH_RDATA;
            end
          end
        end
        PH_RDATA: begin
          for (int i = 0; i < RDATA_BYTES; i++) begin
            if (ridx_r == CW'(i)) begin
              cap_store[i] = data_byte;
            end
          end
          if (ridx_r != CW'(RDATA_BYTES)) begin
            cap_ridx = ridx_r + CW'(1);
          end
          cap_left = left_dec;
          if (left_dec == 16'd0) begin
            emit = 1'b1;
          end
        end
        default: begin
        end
      endcase
      // answer complete: count it off
      if (emit) begin
        cap_ans_left = ans_left_r - 16'd1;
        if (cap_ans_left == 16'd0) begin
          cap_phase = PH_DONE;
        end else begin
          start_rec = 1'b1;
          cap_phase = PH_ANAME;
        end
      end
    end
  end

  // Record fields from the captured answer
  always_comb begin
    flat = '0;
    for (int i = 0; i < RDATA_BYTES; i++) begin
      flat[8*(dnsrp_pkg::RDATA_MAX-1-i) +: 8] = cap_store[i];
    end
    if (cap_type == dnsrp_pkg::TYPE_A && cap_len == dnsrp_pkg::LEN_IPV4) begin
      addr_kind = dnsrp_pkg::ADDR_IPV4;
    end else if (cap_type == dnsrp_pkg::TYPE_AAAA && cap_len == dnsrp_pkg::LEN_IPV6) begin
      addr_kind = dnsrp_pkg::ADDR_IPV6;
    end else begin
      addr_kind = dnsrp_pkg::ADDR_OTHER;
    end
    record              = '0;
    record.result_kind  = dnsrp_pkg::KIND_RECORD;
    record.name_word    = cap_name;
    record.record_type  = cap_type;
    record.record_class = cap_class;
    record.time_to_live = cap_ttl;
    record.rdata_length = cap_len;
    record.rdata_front  = flat[8*dnsrp_pkg::RDATA_MAX-1 -: 64];
    record.rdata_back   = flat[63:0];
    record.address_kind = addr_kind;
    record.status       = (cap_len > 16'(RDATA_BYTES)) ? dnsrp_pkg::STATUS_CLIPPED
                                                        : dnsrp_pkg::STATUS_OK;
    record.last_of_run  = ~last_byte;
    summary              = '0;
    summary.result_kind  = dnsrp_pkg::KIND_SUMMARY;
    summary.answer_total = cap_decl;
    summary.status       = (cap_phase == PH_DONE) ? dnsrp_pkg::STATUS_OK
                                                  : dnsrp_pkg::STATUS_EARLY;
    summary.last_of_run  = 1'b1;
  end

  // Results for this byte: a record, a summary, or a record then a summary
  always_comb begin
    push.first  = take & (emit | last_byte);
    push.second = take & emit & last_byte;
    res0        = emit ? record : summary;
    res1        = summary;
  end

  // Next state: message end restarts, a new answer clears its capture
  always_comb begin
    phase_nxt    = cap_phase;
    hpos_nxt     = cap_hpos;
    left_nxt     = cap_left;
    ans_left_nxt = cap_ans_left;
    decl_nxt     = cap_decl;
    name_nxt     = cap_name;
    seen_nxt     = cap_seen;
    type_nxt     = cap_type;
    class_nxt    = cap_class;
    ttl_nxt      = cap_ttl;
    len_nxt      = cap_len;
    store_nxt    = cap_store;
    ridx_nxt     = cap_ridx;
    if (start_rec || (take && last_byte)) begin
      name_nxt  = '0;
      seen_nxt  = '0;
      type_nxt  = '0;
      class_nxt = '0;
      ttl_nxt   = '0;
      len_nxt   = '0;
      ridx_nxt  = '0;
      for (int i = 0; i < RDATA_BYTES; i++) begin
        store_nxt[i] = 8'h00;
      end
    end
    if (take && last_byte) begin
      phase_nxt    = PH_HEADER;
      hpos_nxt     = '0;
      left_nxt     = '0;
      ans_left_nxt = '0;
      decl_nxt     = '0;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      hpos_r     <= '0;
      left_r     <= '0;
      ans_left_r <= '0;
      decl_r     <= '0;
      name_r     <= '0;
      seen_r     <= '0;
      type_r     <= '0;
      class_r    <= '0;
      ttl_r      <= '0;
      len_r      <= '0;
      ridx_r     <= '0;
      for (int i = 0; i < RDATA_BYTES; i++) begin
        store_r[i] <= 8'h00;
      end
    end else begin
      phase_r    <= phase_nxt;
      hpos_r     <= hpos_nxt;
      left_r     <= left_nxt;
      ans_left_r <= ans_left_nxt;
      decl_r     <= decl_nxt;
      name_r     <= name_nxt;
      seen_r     <= seen_nxt;
      type_r     <= type_nxt;
      class_r    <= class_nxt;
      ttl_r      <= ttl_nxt;
      len_r      <= len_nxt;
      ridx_r     <= ridx_nxt;
      store_r    <= store_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/dnsrp_result_queue.sv */
// Small result queue between the parser and the output channel.
`default_nettype none

module dnsrp_result_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dnsrp_pkg::push_t   push,
  input  wire dnsrp_pkg::result_t res0,
  input  wire dnsrp_pkg::result_t res1,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output dnsrp_pkg::result_t      head
);

  localparam int unsigned PW = dnsrp_pkg::QUEUE_PW;

  dnsrp_pkg::result_t entry_r [dnsrp_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   count_r, count_nxt, push_n;
  logic          pop;

  // Room for two pushes is needed before a byte is taken
  assign in_stall  = (count_r > (PW+1)'(dnsrp_pkg::QUEUE_DEPTH - 2));
  assign out_valid = (count_r != '0);
  assign head      = entry_r[rd_ptr_r];
  assign pop       = out_valid & ~out_stall;
  assign push_n    = (PW+1)'(push.first) + (PW+1)'(push.second);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PW'(push_n);
    rd_ptr_nxt = rd_ptr_r + PW'(pop);
    count_nxt  = count_r + push_n - (PW+1)'(pop);
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push.first) begin
      entry_r[wr_ptr_r] <= res0;
    end
    if (push.second) begin
      entry_r[wr_ptr_r + PW'(1)] <= res1;
    end
  end

endmodule

`default_nettype wire

/* tb/dnsrp_checker.sv */
// Result checker for the DNS response parser: byte-level prediction and field compare.
`timescale 1ns / 1ps

module dnsrp_checker #(
  parameter int unsigned RDATA_BYTES = dnsrp_pkg::DNSRP_RDATA_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_result_kind,
  input  logic [15:0] out_name_word,
  input  logic [15:0] out_record_type,
  input  logic [15:0] out_record_class,
  input  logic [31:0] out_time_to_live,
  input  logic [15:0] out_rdata_length,
  input  logic [63:0] out_rdata_front,
  input  logic [63:0] out_rdata_back,
  input  logic [1:0]  out_address_kind,
  input  logic [15:0] out_answer_total,
  input  logic [1:0]  out_status,
  input  logic        out_last_of_run,
  output int          fail_count,
  output int          pending_results
);

  import dnsrp_pkg::*;

  // Where the parser stands within a message
  typedef enum logic [3:0] {
    P_HEADER, P_QNAME, P_QLABEL, P_QPTR, P_QTAIL,
    P_ANAME, P_ALABEL, P_APTR, P_FIXED, P_RDATA, P_DONE
  } parse_phase_e;

  parse_phase_e phase;
  logic [3:0]   field_pos;
  logic [15:0]  skip_left;
  logic [15:0]  answers_left;
  logic [15:0]  answer_count;
  logic [15:0]  name_hold;
  logic [15:0]  type_hold;
  logic [15:0]  class_hold;
  logic [31:0]  ttl_hold;
  logic [15:0]  rdlen_hold;
  logic [7:0]   rdata_hold [16];
  int           name_bytes;

  result_t      expected_results [$];
  result_t      want;
  int           errors = 0;

  function automatic void clear_record_fields();
    int i;
    for (i = 0; i < 16; i++) rdata_hold[i] = 8'h00;
    name_hold  = '0;
    type_hold  = '0;
    class_hold = '0;
    ttl_hold   = '0;
    rdlen_hold = '0;
    name_bytes = 0;
  endfunction

  function automatic void clear_parser();
    clear_record_fields();
    phase        = P_HEADER;
    field_pos    = '0;
    skip_left    = '0;
    answers_left = '0;
    answer_count = '0;
  endfunction

  function automatic void open_record();
    clear_record_fields();
    phase = P_ANAME;
  endfunction

  function automatic void finish_name(input bit in_answer);
    phase     = in_answer ? P_FIXED : P_QTAIL;
    field_pos = '0;
  endfunction

  // End of name, compression pointer, or label length
  function automatic void name_byte(input logic [7:0] b, input bit in_answer);
    if (b == NAME_END) begin
      finish_name(in_answer);
    end else if ((b & PTR_MASK) == PTR_MASK) begin
      phase = in_answer ? P_APTR : P_QPTR;
    end else begin
      skip_left = {8'h00, b};
      phase     = in_answer ? P_ALABEL : P_QLABEL;
    end
  endfunction

  // Build the record for the answer just finished and move on
  function automatic result_t close_record();
    result_t r;
    int      i;
    r = '0;
    r.result_kind  = KIND_RECORD;
    r.name_word    = name_hold;
    r.record_type  = type_hold;
    r.record_class = class_hold;
    r.time_to_live = ttl_hold;
    r.rdata_length = rdlen_hold;
    for (i = 0; i < 8; i++) begin
      r.rdata_front = {r.rdata_front[55:0], rdata_hold[i]};
      r.rdata_back  = {r.rdata_back[55:0], rdata_hold[i + 8]};
    end
    if (type_hold == TYPE_A && rdlen_hold == LEN_IPV4) r.address_kind = ADDR_IPV4;
    else if (type_hold == TYPE_AAAA && rdlen_hold == LEN_IPV6) r.address_kind = ADDR_IPV6;
    else r.address_kind = ADDR_OTHER;
    r.status = (rdlen_hold > RDATA_BYTES) ? STATUS_CLIPPED : STATUS_OK;
    answers_left = answers_left - 16'd1;
    if (answers_left == 16'd0) phase = P_DONE;
    else open_record();
    return r;
  endfunction

  // Advance the parser by one byte and queue the results it gives
  task automatic predict_byte(input logic [7:0] b, input logic last);
    result_t     outs [2];
    int          n;
    int          i;
    logic [15:0] idx;
    n = 0;

    // the first two bytes of each answer form the name word
    if (phase >= P_ANAME && phase <= P_RDATA && name_bytes < 2) begin
      name_hold  = {name_hold[7:0], b};
      name_bytes = name_bytes + 1;
    end

    case (phase)
      P_HEADER: begin
        if (field_pos == COUNT_HI_POS) answer_count = {b, 8'h00};
        else if (field_pos == COUNT_LO_POS) answer_count = answer_count | {8'h00, b};
        if (field_pos >= HEADER_LAST) begin
          answers_left = answer_count;
          phase        = P_QNAME;
          field_pos    = '0;
        end else begin
          field_pos = field_pos + 4'd1;
        end
      end
      P_QNAME: name_byte(b, 1'b0);
      P_ANAME: name_byte(b, 1'b1);
      P_QLABEL, P_ALABEL: begin
        skip_left = skip_left - 16'd1;
        if (skip_left == 16'd0) phase = (phase == P_QLABEL) ? P_QNAME : P_ANAME;
      end
      P_QPTR: finish_name(1'b0);
      P_APTR: finish_name(1'b1);
      P_QTAIL: begin
        field_pos = field_pos + 4'd1;
        if (field_pos >= QTAIL_BYTES) begin
          field_pos = '0;
          if (answers_left == 16'd0) phase = P_DONE;
          else open_record();
        end
      end
      P_FIXED: begin
        if (field_pos < 4'd2) type_hold = {type_hold[7:0], b};
        else if (field_pos < 4'd4) class_hold = {class_hold[7:0], b};
        else if (field_pos < 4'd8) ttl_hold = {ttl_hold[23:0], b};
        else rdlen_hold = {rdlen_hold[7:0], b};
        field_pos = field_pos + 4'd1;
        if (field_pos >= FIXED_BYTES) begin
          field_pos = '0;
          if (rdlen_hold == 16'd0) begin
            outs[n] = close_record();
            n = n + 1;
          end else begin
            skip_left = rdlen_hold;
            phase     = P_RDATA;
          end
        end
      end
      P_RDATA: begin
        idx = rdlen_hold - skip_left;
        if (idx < RDATA_BYTES) rdata_hold[idx[3:0]] = b;
        skip_left = skip_left - 16'd1;
        if (skip_left == 16'd0) begin
          outs[n] = close_record();
          n = n + 1;
        end
      end
      default: ;
    endcase

    // last byte: summary, then back to a fresh message
    if (last) begin
      outs[n] = '0;
      outs[n].result_kind  = KIND_SUMMARY;
      outs[n].answer_total = answer_count;
      outs[n].status       = (phase == P_DONE) ? STATUS_OK : STATUS_EARLY;
      n = n + 1;
      clear_parser();
    end
    if (n > 0) outs[n - 1].last_of_run = 1'b1;
    for (i = 0; i < n; i++) expected_results.push_back(outs[i]);
  endtask

  task automatic compare_field(input string field, input logic [63:0] exp_val,
                               input logic [63:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, exp_val, act_val);
      errors = errors + 1;
    end
  endtask

  // Input transfers are predicted before the output transfer of the same edge is checked
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parser();
      expected_results.delete();
    end else begin
      if (in_valid && !in_stall) predict_byte(in_data_byte, in_last_byte);
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no result expected");
          errors = errors + 1;
        end else begin
          want = expected_results.pop_front();
          compare_field("result_kind", want.result_kind, out_result_kind);
          compare_field("name_word", want.name_word, out_name_word);
          compare_field("record_type", want.record_type, out_record_type);
          compare_field("record_class", want.record_class, out_record_class);
          compare_field("time_to_live", want.time_to_live, out_time_to_live);
          compare_field("rdata_length", want.rdata_length, out_rdata_length);
          compare_field("rdata_front", want.rdata_front, out_rdata_front);
          compare_field("rdata_back", want.rdata_back, out_rdata_back);
          compare_field("address_kind", want.address_kind, out_address_kind);
          compare_field("answer_total", want.answer_total, out_answer_total);
          compare_field("status", want.status, out_status);
          compare_field("last_of_run", want.last_of_run, out_last_of_run);
        end
      end
    end
    fail_count      <= errors;
    pending_results <= expected_results.size();
  end

endmodule

/* tb/dns_response_parser_unit_tb.sv */
// Testbench top for the DNS response parser: message stimulus, idling and verdict.
`timescale 1ns / 1ps

module dns_response_parser_unit_tb;

  import dnsrp_pkg::*;

  localparam int ITEM_TARGET  = 1250;
  localparam int MIN_MESSAGES = 20;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_result_kind;
  logic [15:0] out_name_word;
  logic [15:0] out_record_type;
  logic [15:0] out_record_class;
  logic [31:0] out_time_to_live;
  logic [15:0] out_rdata_length;
  logic [63:0] out_rdata_front;
  logic [63:0] out_rdata_back;
  logic [1:0]  out_address_kind;
  logic [15:0] out_answer_total;
  logic [1:0]  out_status;
  logic        out_last_of_run;
  int          fail_count;
  int          pending_results;

  logic [7:0]  msg_bytes [$];
  int          sent_items = 0;
  int          cycle_count = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;

  dns_response_parser_unit #(.RDATA_BYTES(DNSRP_RDATA_BYTES)) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_name_word    (out_name_word),
    .out_record_type  (out_record_type),
    .out_record_class (out_record_class),
    .out_time_to_live (out_time_to_live),
    .out_rdata_length (out_rdata_length),
    .out_rdata_front  (out_rdata_front),
    .out_rdata_back   (out_rdata_back),
    .out_address_kind (out_address_kind),
    .out_answer_total (out_answer_total),
    .out_status       (out_status),
    .out_last_of_run  (out_last_of_run)
  );

  dnsrp_checker #(.RDATA_BYTES(DNSRP_RDATA_BYTES)) u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_name_word    (out_name_word),
    .out_record_type  (out_record_type),
    .out_record_class (out_record_class),
    .out_time_to_live (out_time_to_live),
    .out_rdata_length (out_rdata_length),
    .out_rdata_front  (out_rdata_front),
    .out_rdata_back   (out_rdata_back),
    .out_address_kind (out_address_kind),
    .out_answer_total (out_answer_total),
    .out_status       (out_status),
    .out_last_of_run  (out_last_of_run),
    .fail_count       (fail_count),
    .pending_results  (pending_results)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: random stall, quiet stretch, and long hold-offs on request
  initial begin
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 28);
        @(posedge clk);
      end
    end
  end

  // One byte transfer; payload held until it is taken
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!calm && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items = sent_items + 1;
  endtask

  task automatic send_message();
    int i;
    for (i = 0; i < msg_bytes.size(); i++) send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
  endtask

  task automatic push_random(input int count);
    repeat (count) msg_bytes.push_back(8'($urandom));
  endtask

  // Root name, compression pointer, or labels ending in root or a pointer
  task automatic add_name();
    int pick;
    int len;
    pick = $urandom_range(99);
    if (pick < 20) begin
      msg_bytes.push_back(NAME_END);
    end else if (pick < 50) begin
      msg_bytes.push_back(PTR_MASK | 8'($urandom_range(63)));
      push_random(1);
    end else begin
      repeat ($urandom_range(3, 1)) begin
        len = ($urandom_range(29) == 0) ? $urandom_range(191, 64) : $urandom_range(8, 1);
        msg_bytes.push_back(8'(len));
        push_random(len);
      end
      if ($urandom_range(1)) begin
        msg_bytes.push_back(NAME_END);
      end else begin
        msg_bytes.push_back(PTR_MASK | 8'($urandom_range(63)));
        push_random(1);
      end
    end
  endtask

  // One answer; whole is cleared when a huge rdata length cuts the message there
  task automatic add_answer(output bit whole);
    logic [15:0] rtype;
    logic [15:0] rlen;
    int          pick;
    int          body;
    add_name();
    pick = $urandom_range(99);
    if (pick < 35) rtype = TYPE_A;
    else if (pick < 65) rtype = TYPE_AAAA;
    else rtype = 16'($urandom);
    pick = $urandom_range(99);
    if (rtype == TYPE_A && pick < 70) rlen = LEN_IPV4;
    else if (rtype == TYPE_AAAA && pick < 70) rlen = LEN_IPV6;
    else if (pick < 78) rlen = 16'd0;
    else if (pick < 88) rlen = 16'($urandom_range(20, 1));
    else if (pick < 96) rlen = 16'($urandom_range(40, 17));
    else rlen = $urandom_range(1) ? 16'hFFFF : 16'($urandom);
    msg_bytes.push_back(rtype[15:8]);
    msg_bytes.push_back(rtype[7:0]);
    if ($urandom_range(1)) begin
      msg_bytes.push_back(8'h00);
      msg_bytes.push_back(8'h01);
    end else begin
      push_random(2);
    end
    push_random(4);
    msg_bytes.push_back(rlen[15:8]);
    msg_bytes.push_back(rlen[7:0]);
    body = (rlen > 16'd48) ? $urandom_range(20) : int'(rlen);
    push_random(body);
    whole = (body == int'(rlen));
  endtask

  // Mostly well-formed responses; some noise, some cut short
  task automatic make_message();
    logic [15:0] declared;
    int          pick;
    int          built;
    int          i;
    int          keep;
    bit          whole;
    msg_bytes.delete();
    if ($urandom_range(99) < 8) begin
      push_random($urandom_range(30, 1));
      return;
    end
    pick = $urandom_range(99);
    if (pick < 15) declared = 16'd0;
    else if (pick < 45) declared = 16'd1;
    else if (pick < 70) declared = 16'd2;
    else if (pick < 85) declared = 16'd3;
    else if (pick < 92) declared = 16'hFFFF;
    else declared = 16'($urandom);
    for (i = 0; i < 12; i++) begin
      if (i == COUNT_HI_POS) msg_bytes.push_back(declared[15:8]);
      else if (i == COUNT_LO_POS) msg_bytes.push_back(declared[7:0]);
      else push_random(1);
    end
    add_name();
    push_random(4);
    built = (declared > 16'd3) ? $urandom_range(2) : int'(declared);
    whole = 1'b1;
    for (i = 0; i < built && whole; i++) add_answer(whole);
    // trailing bytes after the answers
    if (whole && $urandom_range(4) == 0) push_random($urandom_range(4, 1));
    if ($urandom_range(99) < 12) begin
      keep = $urandom_range(msg_bytes.size() - 1, 1);
      while (msg_bytes.size() > keep) void'(msg_bytes.pop_back());
    end
  endtask

  initial begin
    int msg_index;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // single byte message, ended before the header
    msg_bytes = '{8'hFF};
    send_message();
    // header cut just after the answer count
    msg_bytes = '{8'h12, 8'h34, 8'h81, 8'h80, 8'h00, 8'h01, 8'h01, 8'h02};
    send_message();
    // no answers, question name as a pointer
    msg_bytes = '{8'hAB, 8'hCD, 8'h81, 8'h80, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00,
                  8'h00, 8'h00, 8'hC0, 8'h0C, 8'h00, 8'h01, 8'h00, 8'h01};
    send_message();

    msg_index = 0;
    while (sent_items < ITEM_TARGET || msg_index < MIN_MESSAGES) begin
      calm = (msg_index >= 12 && msg_index < 18);
      if (msg_index == 6 || msg_index == 19) hold_req = 1'b1;
      make_message();
      send_message();
      msg_index = msg_index + 1;
    end
    calm = 1'b0;
    in_valid <= 1'b0;
    @(posedge clk);

    // let the queue drain, then a short settle
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/dnsrp_pkg.sv
src/dnsrp_parser.sv
src/dnsrp_result_queue.sv
src/dns_response_parser_unit.sv
tb/dnsrp_checker.sv
tb/dns_response_parser_unit_tb.sv
